// File: hw/rtl/restoring_sign_magnitude_divider_defines.svh
// ----------------------------------------------------------------------------
// restoring sign-magnitude divider assertion macros
// shared property wrappers clocked on clk and disabled during reset
// ----------------------------------------------------------------------------
`ifndef RESTORING_SIGN_MAGNITUDE_DIVIDER_DEFINES_SVH
`define RESTORING_SIGN_MAGNITUDE_DIVIDER_DEFINES_SVH

// same-cycle implication
`define RSMD_ASSERT_IMP(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication
`define RSMD_ASSERT_NXT(name, ante, cons, msg) \
	name: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/rsmd_pkg.sv
// ----------------------------------------------------------------------------
// rsmd_pkg
// shared constants and controller/datapath interface types of the divider
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rsmd_pkg;

	localparam int MAX_WORD_BITS_DEF = 12;
	localparam int MIN_WORD_BITS     = 4;
	localparam int CFG_W             = 4;
	localparam logic [CFG_W-1:0] WORD_BITS_RST = 4'd12;

	typedef struct packed {
		logic load;
		logic step;
		logic finish;
	} rsmd_cmd_t;

	typedef struct packed {
		logic ovf;
		logic last;
	} rsmd_sts_t;

endpackage

// File: hw/rtl/rsmd_ctrl.sv
// ----------------------------------------------------------------------------
// rsmd_ctrl
// sequencer: load, one shift-subtract step per cycle, finish, result strobe
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "restoring_sign_magnitude_divider_defines.svh"

module rsmd_ctrl (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	output logic               done,
	output rsmd_pkg::rsmd_cmd_t cmd,
	input  rsmd_pkg::rsmd_sts_t sts
);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_STEP,
		ST_FINISH
	} state_t;

	state_t state_q;
	logic   done_q;

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

	always_comb begin
		cmd.load   = (state_q == ST_IDLE) && start;
		cmd.step   = (state_q == ST_STEP) && !sts.ovf;
		cmd.finish = (state_q == ST_FINISH);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			done_q <= (state_q == ST_FINISH);
			case (state_q)
				ST_IDLE: begin
					if (start) begin
						state_q <= ST_STEP;
					end
				end
				ST_STEP: begin
					if (sts.ovf || sts.last) begin
						state_q <= ST_FINISH;
					end
				end
				ST_FINISH: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	`RSMD_ASSERT_IMP(a_done_idle, done, !busy, "result strobe while busy")
	`RSMD_ASSERT_NXT(a_start_busy, start && !busy, busy, "accepted request did not start")
	`RSMD_ASSERT_NXT(a_finish_done, state_q == ST_FINISH, done, "finish without strobe")
	`RSMD_ASSERT_NXT(a_ovf_skip, (state_q == ST_STEP) && sts.ovf, state_q == ST_FINISH,
		"overflow did not skip steps")

endmodule

// File: hw/rtl/rsmd_dp.sv
// ----------------------------------------------------------------------------
// rsmd_dp
// width register, operand unpacking, restoring step unit and result registers
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsmd_dp #(
	parameter int MAX_WORD_BITS = rsmd_pkg::MAX_WORD_BITS_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [rsmd_pkg::CFG_W-1:0]        cfg_data,
	input  logic [2*MAX_WORD_BITS:0]          dividend_bits,
	input  logic [MAX_WORD_BITS:0]            divisor_bits,
	input  rsmd_pkg::rsmd_cmd_t               cmd,
	output rsmd_pkg::rsmd_sts_t               sts,
	output logic signed [MAX_WORD_BITS:0]     quotient,
	output logic [MAX_WORD_BITS-1:0]          remainder,
	output logic                              overflow,
	output logic [$clog2(2*MAX_WORD_BITS+1)-1:0] op_count
);

	localparam int W   = MAX_WORD_BITS;
	localparam int NW  = $clog2(W + 1);
	localparam int IW  = $clog2(W);
	localparam int DIW = $clog2(2 * W + 1);
	localparam int OW  = $clog2(2 * W + 1);
	localparam int CW  = (NW > rsmd_pkg::CFG_W) ? NW : rsmd_pkg::CFG_W;

	logic [rsmd_pkg::CFG_W-1:0] wb_q;

	logic [CW-1:0]  wb_ext;
	logic [CW-1:0]  n_clamp;
	logic [NW-1:0]  n_eff;
	logic [W-1:0]   mask;
	logic [W-1:0]   upper;
	logic [W-1:0]   lower;
	logic [W-1:0]   dmag;
	logic           s1;
	logic           s2;

	logic [NW-1:0]  n_q;
	logic [W-1:0]   mask_q;
	logic [W:0]     a_q;
	logic [W-1:0]   q_q;
	logic [W-1:0]   dmag_q;
	logic           sgn_q;
	logic           ovf_q;
	logic [IW-1:0]  cnt_q;
	logic [OW-1:0]  ops_q;

	logic [W:0]     a_sh;
	logic [W:0]     a_sub;
	logic           fits;
	logic [W-1:0]   q_sh;
	logic [W:0]     q_pos;

	logic signed [W:0] quotient_q;
	logic [W-1:0]      remainder_q;
	logic              overflow_q;
	logic [OW-1:0]     op_count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wb_q <= rsmd_pkg::WORD_BITS_RST;
		end else if (cfg_we) begin
			wb_q <= cfg_data;
		end
	end

	// clamp width to the supported range
	always_comb begin
		wb_ext = CW'(wb_q);
		if (wb_ext < CW'(rsmd_pkg::MIN_WORD_BITS)) begin
			n_clamp = CW'(rsmd_pkg::MIN_WORD_BITS);
		end else if (wb_ext > CW'(W)) begin
			n_clamp = CW'(W);
		end else begin
			n_clamp = wb_ext;
		end
		n_eff = NW'(n_clamp);
		mask  = W'(({{W{1'b0}}, 1'b1} << n_eff) - 1'b1);
		upper = W'(dividend_bits >> n_eff) & mask;
		lower = dividend_bits[W-1:0] & mask;
		dmag  = divisor_bits[W-1:0] & mask;
		s1    = dividend_bits[DIW'({n_eff, 1'b0})];
		s2    = divisor_bits[n_eff];
	end

	// one restoring step
	always_comb begin
		a_sh  = {a_q[W-1:0], q_q[IW'(n_q - 1'b1)]};
		fits  = (a_sh >= {1'b0, dmag_q});
		a_sub = a_sh - {1'b0, dmag_q};
		q_sh  = (q_q << 1) & mask_q;
		q_pos = {1'b0, q_q};
	end

	assign sts.ovf  = ovf_q;
	assign sts.last = (cnt_q == IW'(n_q - 1'b1));

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			n_q    <= n_eff;
			mask_q <= mask;
			a_q    <= {1'b0, upper};
			q_q    <= lower;
			dmag_q <= dmag;
			sgn_q  <= s1 ^ s2;
			ovf_q  <= (upper >= dmag);
			cnt_q  <= '0;
			ops_q  <= '0;
		end else if (cmd.step) begin
			cnt_q <= cnt_q + 1'b1;
			if (fits) begin
				a_q   <= a_sub;
				q_q   <= q_sh | {{(W-1){1'b0}}, 1'b1};
				ops_q <= ops_q + OW'(1);
			end else begin
				a_q   <= a_sh;
				q_q   <= q_sh;
				ops_q <= ops_q + OW'(2);
			end
		end
		if (cmd.finish) begin
			overflow_q <= ovf_q;
			if (ovf_q) begin
				quotient_q  <= '0;
				remainder_q <= '0;
				op_count_q  <= '0;
			end else begin
				quotient_q  <= sgn_q ? $signed((W+1)'(0) - q_pos) : $signed(q_pos);
				remainder_q <= a_q[W-1:0];
				op_count_q  <= ops_q;
			end
		end
	end

	assign quotient  = quotient_q;
	assign remainder = remainder_q;
	assign overflow  = overflow_q;
	assign op_count  = op_count_q;

endmodule

// File: hw/rtl/restoring_sign_magnitude_divider.sv
// ----------------------------------------------------------------------------
// restoring_sign_magnitude_divider
// sign-magnitude divider with overflow detect and restoring shift-subtract
// ----------------------------------------------------------------------------
// Request channel: drive dividend_bits and divisor_bits and raise start; the
// request is taken at the rising edge where start is high and busy is low.
// busy stays high until the result is registered.
// Result channel: done pulses for one cycle with quotient, remainder, overflow
// and op_count valid in that cycle. The receiver cannot stall, so it must
// capture the result in that cycle; a new request may be taken in the same
// cycle that done is high.
// Sequence: the request is loaded at the accepting edge, then the single shared
// shift-subtract unit retires one quotient bit per cycle, one for each of the n
// bits of the clamped word_bits value, then a finish state applies the sign and
// registers the result; an overflowing request skips the steps. A new request
// is taken only once the previous one has left the busy states.
// Config: cfg_data is written into word_bits when cfg_valid and cfg_ready are
// both high; cfg_ready is high while the divider is idle.
// Reset: arst_n clears the sequencer and sets word_bits to 12; no result is
// pending after reset.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module restoring_sign_magnitude_divider #(
	parameter int MAX_WORD_BITS = rsmd_pkg::MAX_WORD_BITS_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  cfg_valid,
	output logic                                  cfg_ready,
	input  logic [rsmd_pkg::CFG_W-1:0]            cfg_data,
	input  logic                                  start,
	output logic                                  busy,
	input  logic [2*MAX_WORD_BITS:0]              dividend_bits,
	input  logic [MAX_WORD_BITS:0]                divisor_bits,
	output logic                                  done,
	output logic signed [MAX_WORD_BITS:0]         quotient,
	output logic [MAX_WORD_BITS-1:0]              remainder,
	output logic                                  overflow,
	output logic [$clog2(2*MAX_WORD_BITS+1)-1:0]  op_count
);

	rsmd_pkg::rsmd_cmd_t cmd;
	rsmd_pkg::rsmd_sts_t sts;

	assign cfg_ready = !busy;

	rsmd_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.done   (done),
		.cmd    (cmd),
		.sts    (sts)
	);

	rsmd_dp #(
		.MAX_WORD_BITS (MAX_WORD_BITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_valid && cfg_ready),
		.cfg_data      (cfg_data),
		.dividend_bits (dividend_bits),
		.divisor_bits  (divisor_bits),
		.cmd           (cmd),
		.sts           (sts),
		.quotient      (quotient),
		.remainder     (remainder),
		.overflow      (overflow),
		.op_count      (op_count)
	);

endmodule

// File: bench/rsmd_quotient_checker.sv
// ----------------------------------------------------------------------------
// rsmd_quotient_checker
// watches the request, config and result channels of the divider, predicts
// quotient, remainder, overflow and operation count for every accepted request and
// compares each done strobe against the oldest prediction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module rsmd_quotient_checker #(
	parameter int W = rsmd_pkg::MAX_WORD_BITS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_valid,
	input  logic                          cfg_ready,
	input  logic [rsmd_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          start,
	input  logic                          busy,
	input  logic [2*W:0]                  dividend_bits,
	input  logic [W:0]                    divisor_bits,
	input  logic                          done,
	input  logic signed [W:0]             quotient,
	input  logic [W-1:0]                  remainder,
	input  logic                          overflow,
	input  logic [$clog2(2*W+1)-1:0]      op_count,
	output int                            mismatches,
	output int                            outstanding
);

	localparam int OPS_W = $clog2(2*W+1);

	typedef struct packed {
		logic [W:0]       quo;
		logic [W-1:0]     rem;
		logic             ovf;
		logic [OPS_W-1:0] ops;
	} division_t;

	division_t                   pending_divisions[$];
	logic [rsmd_pkg::CFG_W-1:0]  word_bits;
	division_t                   want;

	function automatic division_t divide_sign_magnitude(
		input logic [2*W:0]               dvd,
		input logic [W:0]                 dvs,
		input logic [rsmd_pkg::CFG_W-1:0] wb
	);
		int          n;
		int unsigned nmask, upper, lower, dmag, a, q, ops;
		logic        s_dvd, s_dvs;
		division_t   r;
		n = wb;
		if (n < rsmd_pkg::MIN_WORD_BITS) n = rsmd_pkg::MIN_WORD_BITS;
		if (n > W) n = W;
		nmask = (32'd1 << n) - 1;
		s_dvd = dvd[2*n];
		s_dvs = dvs[n];
		upper = (dvd >> n) & nmask;
		lower = dvd & nmask;
		dmag  = dvs & nmask;
		r = '0;
		if (upper >= dmag) begin
			r.ovf = 1'b1;
			return r;
		end
		a = upper;
		q = lower;
		ops = 0;
		for (int i = 0; i < n; i++) begin
			a = (a << 1) | ((q >> (n - 1)) & 1);
			q = (q << 1) & nmask;
			ops++;
			if (a >= dmag) begin
				a = a - dmag;
				q = q | 1;
			end else begin
				ops++;
			end
		end
		if (s_dvd ^ s_dvs) q = 0 - q;
		r.quo = q[W:0];
		r.rem = a[W-1:0];
		r.ops = ops[OPS_W-1:0];
		return r;
	endfunction

	initial begin
		mismatches = 0;
		outstanding = 0;
	end

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			word_bits = rsmd_pkg::WORD_BITS_RST;
			pending_divisions.delete();
		end else begin
			if (done) begin
				if (pending_divisions.size() == 0) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: result with no request waiting: q=%0d r=%0d ovf=%0b ops=%0d",
							$time, quotient, remainder, overflow, op_count);
				end else begin
					want = pending_divisions.pop_front();
					if (quotient !== want.quo || remainder !== want.rem ||
					    overflow !== want.ovf || op_count !== want.ops) begin
						mismatches++;
						if (mismatches <= 10)
							$display("%0t: expected q=%0d r=%0d ovf=%0b ops=%0d, got q=%0d r=%0d ovf=%0b ops=%0d",
								$time, $signed(want.quo), want.rem, want.ovf, want.ops,
								quotient, remainder, overflow, op_count);
					end
				end
			end
			if (start && !busy)
				pending_divisions.push_back(divide_sign_magnitude(dividend_bits, divisor_bits,
					word_bits));
			if (cfg_valid && cfg_ready) word_bits = cfg_data;
		end
		outstanding = pending_divisions.size();
	end

endmodule

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the restoring sign-magnitude divider: directed
// edge cases, then phases of random requests at several word widths, with random
// sender gaps in all but one phase; a side checker predicts and compares every result
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

	localparam int W        = rsmd_pkg::MAX_WORD_BITS_DEF;
	localparam int CW       = rsmd_pkg::CFG_W;
	localparam int DRAIN    = 3 * W;
	localparam int STALL_MAX = 4000;
	localparam int TARGET   = 1850;

	logic                       clk;
	logic                       arst_n;
	logic                       cfg_valid;
	logic                       cfg_ready;
	logic [CW-1:0]              cfg_data;
	logic                       start;
	logic                       busy;
	logic [2*W:0]               dividend_bits;
	logic [W:0]                 divisor_bits;
	logic                       done;
	logic signed [W:0]          quotient;
	logic [W-1:0]               remainder;
	logic                       overflow;
	logic [$clog2(2*W+1)-1:0]   op_count;

	int          mismatches;
	int          outstanding;
	int          stall_cycles;
	int          sent;
	int          phase_len;
	bit          gaps_on;
	logic [CW-1:0] cur_bits;
	logic [2*W:0]  dvd;
	logic [W:0]    dvs;

	restoring_sign_magnitude_divider uut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.dividend_bits (dividend_bits),
		.divisor_bits  (divisor_bits),
		.done          (done),
		.quotient      (quotient),
		.remainder     (remainder),
		.overflow      (overflow),
		.op_count      (op_count)
	);

	rsmd_quotient_checker quotient_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.start         (start),
		.busy          (busy),
		.dividend_bits (dividend_bits),
		.divisor_bits  (divisor_bits),
		.done          (done),
		.quotient      (quotient),
		.remainder     (remainder),
		.overflow      (overflow),
		.op_count      (op_count),
		.mismatches    (mismatches),
		.outstanding   (outstanding)
	);

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// ends the run when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || (cfg_valid && cfg_ready) || done || !arst_n) begin
			stall_cycles <= 0;
		end else if (stall_cycles >= STALL_MAX) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end else begin
			stall_cycles <= stall_cycles + 1;
		end
	end

	task automatic send_request(input logic [2*W:0] a, input logic [W:0] b);
		bit taken;
		taken = 1'b0;
		if (gaps_on) begin
			while ($urandom_range(99) < 13) begin
				start <= 1'b0;
				@(negedge clk);
			end
		end
		dividend_bits <= a;
		divisor_bits  <= b;
		start         <= 1'b1;
		while (!taken) begin
			@(posedge clk);
			taken = !busy;
			@(negedge clk);
		end
		sent++;
	endtask

	// drop start, let every result come back, then let the block settle
	task automatic drain_requests();
		start <= 1'b0;
		@(negedge clk);
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
	endtask

	task automatic write_word_bits(input logic [CW-1:0] v);
		bit taken;
		taken = 1'b0;
		drain_requests();
		cfg_data  <= v;
		cfg_valid <= 1'b1;
		while (!taken) begin
			@(posedge clk);
			taken = cfg_ready;
			@(negedge clk);
		end
		cfg_valid <= 1'b0;
		cur_bits = v;
	endtask

	task automatic make_request(output logic [2*W:0] a, output logic [W:0] b);
		int              n, kind;
		longint unsigned mask, dmag, upper, lower, x, y;
		n = int'(cur_bits);
		if (n < rsmd_pkg::MIN_WORD_BITS) n = rsmd_pkg::MIN_WORD_BITS;
		if (n > W) n = W;
		mask = (64'd1 << n) - 1;
		kind = $urandom_range(99);
		if (kind < 80) begin
			dmag  = $urandom_range(mask, 1);
			upper = $urandom_range(dmag - 1, 0);
		end else if (kind < 90) begin
			dmag  = $urandom_range(mask, 0);
			upper = $urandom_range(mask, dmag);
		end else begin
			a = (2*W+1)'($urandom);
			b = (W+1)'($urandom);
			return;
		end
		lower = $urandom & mask;
		x = (upper << n) | lower | (longint'($urandom_range(1)) << (2 * n));
		y = dmag | (longint'($urandom_range(1)) << n);
		// occasional junk above the sign bits
		if ($urandom_range(9) == 0) x = x | (longint'($urandom) << (2 * n + 1));
		if ($urandom_range(9) == 0) y = y | (longint'($urandom) << (n + 1));
		a = x[2*W:0];
		b = y[W:0];
	endtask

	initial begin
		arst_n        = 1'b0;
		cfg_valid     = 1'b0;
		cfg_data      = '0;
		start         = 1'b0;
		dividend_bits = '0;
		divisor_bits  = '0;
		stall_cycles  = 0;
		sent          = 0;
		gaps_on       = 1'b1;
		cur_bits      = rsmd_pkg::WORD_BITS_RST;
		repeat (11) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed requests at the reset width of 12
		send_request(25'd0, 13'd1);
		send_request({1'b0, 12'd4094, 12'd4095}, 13'd4095);
		send_request({1'b1, 12'd4094, 12'd4095}, 13'd4095);
		send_request({1'b0, 12'd4094, 12'd4095}, {1'b1, 12'd4095});
		send_request({1'b1, 12'd4094, 12'd4095}, {1'b1, 12'd4095});
		send_request({1'b1, 24'd0}, 13'd5);
		send_request(25'd123, 13'd0);
		send_request({1'b0, 12'd200, 12'd7}, 13'd200);
		send_request(25'h1FFFFFF, 13'h1FFF);
		send_request(25'd1, 13'd4095);
		send_request({1'b0, 12'd0, 12'd4095}, 13'd1);
		send_request({1'b1, 12'd0, 12'd4095}, 13'd1);
		send_request(25'd1000000, {1'b1, 12'd1234});
		send_request({1'b0, 12'd2047, 12'd0}, 13'd2048);

		// narrowest width, with junk above the sign bits
		write_word_bits(4'd4);
		send_request({16'hFFFF, 1'b0, 4'd3, 4'd5}, {8'hFF, 1'b0, 4'd7});
		send_request({16'hFFFF, 1'b1, 4'd14, 4'd15}, {8'hFF, 1'b0, 4'd15});
		send_request({16'hA5A5, 1'b0, 4'd0, 4'd1}, {8'h5A, 1'b1, 4'd15});
		send_request({16'h0000, 1'b0, 4'd9, 4'd1}, {8'h00, 1'b1, 4'd0});

		for (int ph = 0; sent < TARGET; ph++) begin
			case (ph)
				0:       write_word_bits(4'd12);
				1:       write_word_bits(4'd4);
				2:       write_word_bits(4'd0);
				3:       write_word_bits(4'd15);
				4:       write_word_bits(4'd3);
				5:       write_word_bits(4'd13);
				default: write_word_bits(4'($urandom_range(15)));
			endcase
			gaps_on   = (ph != 3);
			phase_len = $urandom_range(160, 100);
			for (int i = 0; i < phase_len && sent < TARGET; i++) begin
				make_request(dvd, dvs);
				send_request(dvd, dvs);
			end
		end

		drain_requests();
		if (mismatches == 0 && outstanding == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end

endmodule
